FILE: hw/rtl/tde_pkg.sv
// ----------------------------------------------------------------------------
// tde_pkg: shared constants and types for the dwell event block
// Sizes of the sample and level stores, request kinds and result status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tde_pkg;

   localparam int MAX_SAMPLES = 4096;
   localparam int MAX_LEVELS  = 256;
   localparam int SMP_AW      = $clog2(MAX_SAMPLES);
   localparam int LVL_AW      = $clog2(MAX_LEVELS);
   localparam int SMP_CW      = SMP_AW + 1;
   localparam int LVL_CW      = LVL_AW + 1;
   localparam int VAL_W       = 16;
   localparam int GAIN_W      = 32;
   localparam int AMP_W       = 48;
   localparam int RSP_DW      = 104;

   typedef enum logic {
      REQ_PUSH = 1'b0,
      REQ_POP  = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_EVENT   = 3'd0,
      ST_DONE    = 3'd1,
      ST_LEVELS  = 3'd2,
      ST_SAMPLES = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/tde_ram.sv
// ----------------------------------------------------------------------------
// tde_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tde_ram #(
   parameter int DW = 16,
   parameter int AW = 8
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata_ff
);

   logic [DW-1:0] mem [(1 << AW)];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/trace_to_dwell_events.sv
// ----------------------------------------------------------------------------
// trace_to_dwell_events: step trace to dwell event converter
// Stores a pushed trace, builds an ordered level table and pops runs.
// ----------------------------------------------------------------------------
// A push word searches the level table for its value and appends the value
// when it is new; the word marked last then sorts the level table by
// insertion and may reverse it. A pop walks its run in the sample RAM and
// then searches the level table for the rank of its level; error and end
// pops go straight to the result. Both RAMs are walked through their
// single read ports. The result register lets a following push proceed
// while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module trace_to_dwell_events
   import tde_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [15:0]       req_tdata,   // [15:0] sample
   input  wire logic              req_tuser,   // [0] req_type
   input  wire logic              req_tlast,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // [11:0] start_index, [24:12] run_length, [32:25] level_rank,
   // [48:33] level_value, [96:49] amplitude, rest zero
   output logic [RSP_DW-1:0]      rsp_tdata,
   output logic [2:0]             rsp_tuser,   // [2:0] status
   output logic                   rsp_tlast,   // final_event
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [GAIN_W-1:0] csr_data
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LOADING,
      PH_READY
   } phase_type;

   typedef enum logic [4:0] {
      S_IDLE, S_SRCH_REQ, S_SRCH_CMP, S_LAST_CHK,
      S_SORT_I, S_SORT_KEY, S_SORT_J, S_SORT_CMP,
      S_REV_A0, S_REV_A1, S_REV_A2,
      S_SWP_RD0, S_SWP_RD1, S_SWP_W0, S_SWP_W1,
      S_POP_V, S_RUN_REQ, S_RUN_CMP, S_RANK_REQ, S_RANK_CMP, S_RANK_DONE,
      S_EMIT
   } state_type;

   state_type          state_ff;
   phase_type          phase_ff;
   logic [SMP_CW-1:0]  sc_ff, rp_ff, p_ff;
   logic [LVL_CW-1:0]  lc_ff, i_ff, j_ff, k_ff;
   logic [1:0]         err_ff;
   logic               last_ff;
   logic signed [VAL_W-1:0]  v_ff, key_ff, a_ff;
   logic signed [GAIN_W-1:0] gain_ff;
   logic signed [AMP_W-1:0]  amp_ff;
   status_type         stat_ff;
   logic [SMP_AW-1:0]  start_ff;
   logic [LVL_AW-1:0]  rank_ff;

   logic               rsp_valid_ff, rsp_last_ff;
   logic [2:0]         rsp_user_ff;
   logic [RSP_DW-1:0]  rsp_data_ff;

   logic               accept, push_ok;
   logic [SMP_CW-1:0]  sc_eff;
   logic [SMP_CW-1:0]  run_len;

   logic               smp_we;
   logic [SMP_AW-1:0]  smp_waddr, smp_raddr;
   logic [VAL_W-1:0]   smp_rd;
   logic               lvl_we;
   logic [LVL_AW-1:0]  lvl_waddr, lvl_raddr;
   logic [VAL_W-1:0]   lvl_wdata, lvl_rd;
   logic [VAL_W:0]     mag_lo, mag_hi;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign sc_eff     = (phase_ff == PH_LOADING) ? sc_ff : '0;
   assign push_ok    = sc_eff < SMP_CW'(MAX_SAMPLES);
   assign run_len    = p_ff - {1'b0, start_ff};
   assign mag_lo     = a_ff[VAL_W-1] ? -{a_ff[VAL_W-1], a_ff} : {1'b0, a_ff};
   assign mag_hi     = lvl_rd[VAL_W-1] ? -{lvl_rd[VAL_W-1], lvl_rd} : {1'b0, lvl_rd};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // memory port steering
   always_comb begin
      smp_we    = accept && (req_tuser == REQ_PUSH) && push_ok;
      smp_waddr = sc_eff[SMP_AW-1:0];
      smp_raddr = p_ff[SMP_AW-1:0];
      if (state_ff == S_IDLE) begin
         smp_raddr = rp_ff[SMP_AW-1:0];
      end
      lvl_we    = 1'b0;
      lvl_waddr = lc_ff[LVL_AW-1:0];
      lvl_wdata = v_ff;
      lvl_raddr = k_ff[LVL_AW-1:0];
      unique case (state_ff)
         S_SRCH_REQ: begin
            lvl_we = (k_ff >= lc_ff) && (lc_ff < LVL_CW'(MAX_LEVELS));
         end
         S_SORT_I:   lvl_raddr = i_ff[LVL_AW-1:0];
         S_SORT_J: begin
            lvl_raddr = LVL_AW'(j_ff - 1'b1);
            lvl_we    = (j_ff == '0);
            lvl_waddr = j_ff[LVL_AW-1:0];
            lvl_wdata = key_ff;
         end
         S_SORT_CMP: begin
            lvl_we    = 1'b1;
            lvl_waddr = j_ff[LVL_AW-1:0];
            lvl_wdata = ($signed(lvl_rd) > key_ff) ? lvl_rd : key_ff;
         end
         S_REV_A0:   lvl_raddr = '0;
         S_REV_A1:   lvl_raddr = j_ff[LVL_AW-1:0];
         S_SWP_RD0:  lvl_raddr = i_ff[LVL_AW-1:0];
         S_SWP_RD1:  lvl_raddr = j_ff[LVL_AW-1:0];
         S_SWP_W0: begin
            lvl_we    = 1'b1;
            lvl_waddr = i_ff[LVL_AW-1:0];
            lvl_wdata = lvl_rd;
         end
         S_SWP_W1: begin
            lvl_we    = 1'b1;
            lvl_waddr = j_ff[LVL_AW-1:0];
            lvl_wdata = a_ff;
         end
         default: begin
         end
      endcase
   end

   tde_ram #(.DW(VAL_W), .AW(SMP_AW)) u_smp (
      .clock    (clock),
      .we       (smp_we),
      .waddr    (smp_waddr),
      .wdata    (req_tdata),
      .raddr    (smp_raddr),
      .rdata_ff (smp_rd)
   );

   tde_ram #(.DW(VAL_W), .AW(LVL_AW)) u_lvl (
      .clock    (clock),
      .we       (lvl_we),
      .waddr    (lvl_waddr),
      .wdata    (lvl_wdata),
      .raddr    (lvl_raddr),
      .rdata_ff (lvl_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         sc_ff        <= '0;
         lc_ff        <= '0;
         rp_ff        <= '0;
         err_ff       <= '0;
         gain_ff      <= GAIN_W'(65536);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            gain_ff <= csr_data;
         end
         if (rsp_valid_ff && rsp_tready && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_tuser == REQ_PUSH) begin
                  v_ff    <= req_tdata;
                  last_ff <= req_tlast;
                  k_ff    <= '0;
                  if (phase_ff != PH_LOADING) begin
                     lc_ff    <= '0;
                     rp_ff    <= '0;
                     phase_ff <= PH_LOADING;
                  end
                  if (push_ok) begin
                     sc_ff    <= sc_eff + 1'b1;
                     err_ff   <= (phase_ff != PH_LOADING) ? 2'b00 : err_ff;
                     state_ff <= S_SRCH_REQ;
                  end else begin
                     sc_ff    <= sc_eff;
                     err_ff   <= err_ff | 2'b10;
                     state_ff <= S_LAST_CHK;
                  end
               end else if (accept) begin
                  start_ff <= rp_ff[SMP_AW-1:0];
                  p_ff     <= rp_ff + 1'b1;
                  if (phase_ff != PH_READY || sc_ff == '0) begin
                     stat_ff  <= ST_EMPTY;
                     state_ff <= S_EMIT;
                  end else if (err_ff[0]) begin
                     stat_ff  <= ST_LEVELS;
                     state_ff <= S_EMIT;
                  end else if (err_ff[1]) begin
                     stat_ff  <= ST_SAMPLES;
                     state_ff <= S_EMIT;
                  end else if (rp_ff >= sc_ff) begin
                     stat_ff  <= ST_DONE;
                     state_ff <= S_EMIT;
                  end else begin
                     stat_ff  <= ST_EVENT;
                     state_ff <= S_POP_V;
                  end
               end
            end
            S_SRCH_REQ: begin
               if (k_ff >= lc_ff) begin
                  if (lc_ff < LVL_CW'(MAX_LEVELS)) begin
                     lc_ff <= lc_ff + 1'b1;
                  end else begin
                     err_ff <= err_ff | 2'b01;
                  end
                  state_ff <= S_LAST_CHK;
               end else begin
                  state_ff <= S_SRCH_CMP;
               end
            end
            S_SRCH_CMP: begin
               if (lvl_rd == v_ff) begin
                  state_ff <= S_LAST_CHK;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_SRCH_REQ;
               end
            end
            S_LAST_CHK: begin
               if (last_ff) begin
                  rp_ff    <= '0;
                  phase_ff <= PH_READY;
                  i_ff     <= LVL_CW'(1);
                  state_ff <= S_SORT_I;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_SORT_I: begin
               if (i_ff >= lc_ff) begin
                  j_ff     <= lc_ff - 1'b1;
                  i_ff     <= '0;
                  state_ff <= (lc_ff > LVL_CW'(1)) ? S_REV_A0 : S_IDLE;
               end else begin
                  state_ff <= S_SORT_KEY;
               end
            end
            S_SORT_KEY: begin
               key_ff   <= lvl_rd;
               j_ff     <= i_ff;
               state_ff <= S_SORT_J;
            end
            S_SORT_J: begin
               if (j_ff == '0) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_SORT_I;
               end else begin
                  state_ff <= S_SORT_CMP;
               end
            end
            S_SORT_CMP: begin
               if ($signed(lvl_rd) > key_ff) begin
                  j_ff     <= j_ff - 1'b1;
                  state_ff <= S_SORT_J;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_SORT_I;
               end
            end
            S_REV_A0: state_ff <= S_REV_A1;
            S_REV_A1: begin
               a_ff     <= lvl_rd;
               state_ff <= S_REV_A2;
            end
            S_REV_A2: begin
               // gain scales both ends alike: only its zero case matters
               state_ff <= (gain_ff != '0 && mag_hi < mag_lo) ? S_SWP_RD0 : S_IDLE;
            end
            S_SWP_RD0: state_ff <= (i_ff >= j_ff) ? S_IDLE : S_SWP_RD1;
            S_SWP_RD1: begin
               a_ff     <= lvl_rd;
               state_ff <= S_SWP_W0;
            end
            S_SWP_W0: state_ff <= S_SWP_W1;
            S_SWP_W1: begin
               i_ff     <= i_ff + 1'b1;
               j_ff     <= j_ff - 1'b1;
               state_ff <= S_SWP_RD0;
            end
            S_POP_V: begin
               v_ff     <= smp_rd;
               k_ff     <= '0;
               state_ff <= S_RUN_REQ;
            end
            S_RUN_REQ: state_ff <= (p_ff >= sc_ff) ? S_RANK_REQ : S_RUN_CMP;
            S_RUN_CMP: begin
               if (smp_rd == v_ff) begin
                  p_ff     <= p_ff + 1'b1;
                  state_ff <= S_RUN_REQ;
               end else begin
                  state_ff <= S_RANK_REQ;
               end
            end
            S_RANK_REQ: begin
               if (k_ff >= lc_ff) begin
                  rank_ff  <= '0;
                  state_ff <= S_RANK_DONE;
               end else begin
                  state_ff <= S_RANK_CMP;
               end
            end
            S_RANK_CMP: begin
               if (lvl_rd == v_ff) begin
                  rank_ff  <= k_ff[LVL_AW-1:0];
                  state_ff <= S_RANK_DONE;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_RANK_REQ;
               end
            end
            S_RANK_DONE: begin
               amp_ff   <= v_ff * gain_ff;
               rp_ff    <= p_ff;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= stat_ff;
                  if (stat_ff == ST_EVENT) begin
                     rsp_data_ff <= {7'b0, amp_ff, v_ff, rank_ff, run_len, start_ff};
                     rsp_last_ff <= (rp_ff >= sc_ff);
                  end else begin
                     rsp_data_ff <= '0;
                     rsp_last_ff <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/tde_checker.sv
// ----------------------------------------------------------------------------
// tde_checker: port-level assertions for the dwell event block
// Watches the result channel; bound to the top level below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tde_checker
   import tde_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [RSP_DW-1:0] rsp_tdata,
   input wire logic [2:0]        rsp_tuser,
   input wire logic              rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word right after reset");

   a_nonevent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_EVENT |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("non-event word carries payload");

   a_event_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_EVENT |-> rsp_tdata[24:12] != '0)
      else $error("event with zero run length");

endmodule

bind trace_to_dwell_events tde_checker u_tde_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
